// ===== src/scs_pkg.sv =====
// Shared widths, codes and control structs for the segment coverage statistics block.
package scs_pkg;

    localparam int MAX_LEN_DEF = 65536;
    localparam int POS_W       = 17;
    localparam int COV_W       = 16;
    localparam int FRAC_W      = 16;
    localparam int SUM_W       = 32;
    localparam int VAR_W       = 46;
    localparam int SD_W        = 32;
    localparam int CV_W        = 26;
    localparam int ACC_W       = 82;
    localparam int DIVS_W      = 32;
    localparam int RAD_W       = VAR_W + FRAC_W;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int LIM_W       = 25;

    localparam logic [1:0] DIV_MEAN = 2'd0;
    localparam logic [1:0] DIV_VAR  = 2'd1;
    localparam logic [1:0] DIV_CV   = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       clr_step;
        logic       div_start;
        logic [1:0] div_sel;
        logic       pass_issue;
        logic       sqrt_start;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic n_zero;
        logic issue_done;
        logic pipe_empty;
        logic div_done;
        logic sqrt_done;
        logic mean_zero;
        logic out_free;
    } t_sts;

endpackage

// ===== src/scs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scs_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/scs_div.sv =====
// Restoring divider, one quotient bit per cycle.
module scs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [scs_pkg::ACC_W-1:0]  i_dividend,
    input  logic [scs_pkg::DIVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [scs_pkg::ACC_W-1:0]  o_quotient
);
    import scs_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);

    logic [ACC_W-1:0]  r_q;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_d;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W:0]   rem_sh;
    logic              q_bit;
    logic [DIVS_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_q[ACC_W-1]};
        q_bit   = rem_sh >= {1'b0, r_d};
        rem_sub = rem_sh - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(ACC_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            r_q   <= {r_q[ACC_W-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== src/scs_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module scs_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [scs_pkg::RAD_W-1:0]  i_radicand,
    output logic                       o_done,
    output logic [scs_pkg::ROOT_W-1:0] o_root
);
    import scs_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  test;
    logic              fits;

    always_comb begin
        trial = {r_rem, r_x[RAD_W-1 -: 2]};
        test  = {2'b00, r_root, 2'b01};
        fits  = trial >= test;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RAD_W-3:0], 2'b00};
            r_rem  <= fits ? REM_W'(trial - test) : REM_W'(trial);
            r_root <= {r_root[ROOT_W-2:0], fits};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== src/scs_dp.sv =====
// Datapath: coverage store, running sum, squared-deviation pass, divider, root, output register.
module scs_dp #(
    parameter int MAX_LEN = scs_pkg::MAX_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scs_pkg::t_cmd               i_cmd,
    output scs_pkg::t_sts               o_sts,
    input  logic [scs_pkg::POS_W-1:0]   i_position,
    input  logic [scs_pkg::COV_W-1:0]   i_coverage,
    input  logic                        i_last,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [scs_pkg::POS_W-1:0]   o_segment_length,
    output logic [scs_pkg::SUM_W-1:0]   o_mean_value,
    output logic [scs_pkg::VAR_W-1:0]   o_pop_variance,
    output logic [scs_pkg::SD_W-1:0]    o_std_dev,
    output logic [scs_pkg::CV_W-1:0]    o_coef_var,
    output logic                        o_cv_undefined,
    output logic                        o_overflowed
);
    import scs_pkg::*;

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [LIM_W-1:0] LIM = LIM_W'(MAX_LEN);
    localparam int SQ_W = 2 * SUM_W;

    // accumulation state
    logic [SUM_W-1:0]  r_sum;
    logic              r_ovf;
    logic [SUM_W-1:0]  r_seg_sum;
    logic              r_seg_ovf;
    logic [POS_W-1:0]  r_n;
    logic [ADDR_W-1:0] r_clr;
    logic [POS_W-1:0]  r_idx;
    logic [ACC_W-1:0]  r_acc;
    logic [SUM_W-1:0]  r_mean;
    logic [VAR_W-1:0]  r_var;
    logic [SD_W-1:0]   r_sd;
    logic [CV_W-1:0]   r_cv;
    logic [1:0]        r_div_sel;

    // pass pipeline
    logic              r_pa_v;
    logic              r_pa_inr;
    logic              r_pb_v;
    logic [SUM_W-1:0]  r_d;
    logic              r_pc_v;
    logic [SQ_W-1:0]   r_prod;

    logic              pos_inr;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_next;
    logic              idx_inr;
    logic [ADDR_W-1:0] ram_waddr;
    logic [COV_W-1:0]  ram_wdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [COV_W-1:0]  ram_rdata;
    logic [COV_W-1:0]  cov_rd;
    logic [SUM_W-1:0]  cov_fx;
    logic [ACC_W-1:0]  div_num;
    logic [DIVS_W-1:0] div_den;
    logic              div_done;
    logic [ACC_W-1:0]  div_q;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    always_comb begin
        pos_inr  = (i_position != '0) && (LIM_W'(i_position) <= LIM);
        sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(i_coverage);
        sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        idx_inr  = LIM_W'(r_idx) < LIM;
        ram_raddr = ADDR_W'(r_idx);
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        if (i_cmd.clr_step) begin
            ram_we = 1'b1;
        end else if (i_cmd.pass_issue) begin
            // clear each entry as it is read
            ram_we    = idx_inr;
            ram_waddr = ram_raddr;
        end else if (i_cmd.accept && pos_inr) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(i_position - POS_W'(1));
            ram_wdata = i_coverage;
        end
    end

    scs_ram #(
        .WIDTH (COV_W),
        .DEPTH (MAX_LEN),
        .ADDR_W(ADDR_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_ovf  <= 1'b0;
            r_clr  <= '0;
            r_pa_v <= 1'b0;
            r_pb_v <= 1'b0;
            r_pc_v <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.accept) begin
                if (i_last) begin
                    r_sum <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    if (pos_inr) begin
                        r_sum <= sum_next;
                    end
                    r_ovf <= r_ovf | !pos_inr;
                end
            end
            r_pa_v <= i_cmd.pass_issue;
            r_pb_v <= r_pa_v;
            r_pc_v <= r_pb_v;
        end
    end

    always_comb begin
        cov_rd = r_pa_inr ? ram_rdata : '0;
        cov_fx = SUM_W'({cov_rd, FRAC_W'(0)});
    end

    always_ff @(posedge i_clk) begin
        r_pa_inr <= idx_inr;
        r_d      <= (cov_fx >= r_mean) ? cov_fx - r_mean : r_mean - cov_fx;
        r_prod   <= SQ_W'(r_d) * SQ_W'(r_d);
        if (i_cmd.accept && i_last) begin
            r_n       <= i_position;
            r_seg_sum <= pos_inr ? sum_next : r_sum;
            r_seg_ovf <= r_ovf | !pos_inr;
            r_idx     <= '0;
            r_acc     <= '0;
            r_mean    <= '0;
            r_var     <= '0;
            r_sd      <= '0;
            r_cv      <= '0;
        end else begin
            if (i_cmd.pass_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_pc_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (div_done) begin
                case (r_div_sel)
                    DIV_MEAN: r_mean <= (div_q[ACC_W-1:SUM_W] != '0) ? '1 : div_q[SUM_W-1:0];
                    DIV_VAR:  r_var  <= (div_q[ACC_W-1:FRAC_W+VAR_W] != '0) ? '1 :
                                        div_q[FRAC_W+VAR_W-1:FRAC_W];
                    DIV_CV:   r_cv   <= (div_q[ACC_W-1:CV_W] != '0) ? '1 : div_q[CV_W-1:0];
                    default:  r_cv   <= r_cv;
                endcase
            end
            if (sqrt_done) begin
                r_sd <= SD_W'(sqrt_root);
            end
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_MEAN: begin
                div_num = ACC_W'({r_seg_sum, FRAC_W'(0)});
                div_den = DIVS_W'(r_n);
            end
            DIV_VAR: begin
                div_num = r_acc;
                div_den = DIVS_W'(r_n);
            end
            DIV_CV: begin
                div_num = ACC_W'({r_sd, FRAC_W'(0)});
                div_den = r_mean;
            end
            default: begin
                div_num = '0;
                div_den = '1;
            end
        endcase
    end

    scs_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(div_num),
        .i_divisor (div_den),
        .o_done    (div_done),
        .o_quotient(div_q)
    );

    scs_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.sqrt_start),
        .i_radicand({r_var, FRAC_W'(0)}),
        .o_done    (sqrt_done),
        .o_root    (sqrt_root)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_segment_length <= r_n;
            o_mean_value     <= r_mean;
            o_pop_variance   <= r_var;
            o_std_dev        <= r_sd;
            o_coef_var       <= r_cv;
            o_cv_undefined   <= r_mean == '0;
            o_overflowed     <= r_seg_ovf;
        end
    end

    always_comb begin
        o_sts.clear_last = r_clr == ADDR_W'(MAX_LEN - 1);
        o_sts.n_zero     = r_n == '0;
        o_sts.issue_done = r_idx == r_n;
        o_sts.pipe_empty = !(r_pa_v || r_pb_v || r_pc_v);
        o_sts.div_done   = div_done;
        o_sts.sqrt_done  = sqrt_done;
        o_sts.mean_zero  = r_mean == '0;
        o_sts.out_free   = !o_out_valid || !i_out_stall;
    end

endmodule

// ===== src/scs_ctrl.sv =====
// Controller: sequences store clearing, sample intake and the statistics pass.
module scs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last,
    output logic          o_in_stall,
    output scs_pkg::t_cmd o_cmd,
    input  scs_pkg::t_sts i_sts
);
    import scs_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_MEANST = 4'd2;
    localparam logic [3:0] S_MEANW  = 4'd3;
    localparam logic [3:0] S_PASS   = 4'd4;
    localparam logic [3:0] S_VARST  = 4'd5;
    localparam logic [3:0] S_VARW   = 4'd6;
    localparam logic [3:0] S_SQST   = 4'd7;
    localparam logic [3:0] S_SQW    = 4'd8;
    localparam logic [3:0] S_CVST   = 4'd9;
    localparam logic [3:0] S_CVW    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_stall = r_state != S_IDLE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_last) begin
                    n_state = S_MEANST;
                end
            end
            S_MEANST: begin
                if (i_sts.n_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_MEAN;
                    n_state = S_MEANW;
                end
            end
            S_MEANW: begin
                if (i_sts.div_done) begin
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                o_cmd.pass_issue = !i_sts.issue_done;
                if (i_sts.issue_done && i_sts.pipe_empty) begin
                    n_state = S_VARST;
                end
            end
            S_VARST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_VAR;
                n_state = S_VARW;
            end
            S_VARW: begin
                if (i_sts.div_done) begin
                    n_state = S_SQST;
                end
            end
            S_SQST: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQW;
            end
            S_SQW: begin
                if (i_sts.sqrt_done) begin
                    n_state = i_sts.mean_zero ? S_OUT : S_CVST;
                end
            end
            S_CVST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_CV;
                n_state = S_CVW;
            end
            S_CVW: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/segment_coverage_statistics.sv =====
// Segment coverage statistics: top level joining controller and datapath.
//
// Input channel (i_in_valid / o_in_stall) carries one coverage sample per
// transaction: position, coverage and a last flag. Samples are taken one per
// cycle unless stalled. The transaction with last set closes the segment;
// its position is the segment length n, and it produces one result
// transaction on the output channel (o_out_valid / i_out_stall): mean,
// population variance, standard deviation, coefficient of variation and
// flags, 16 fraction bits. After the closing sample the input stalls for
// the statistics run: three divisions, a root, the store pass (one store
// entry per cycle through a single read port) and sequencing; a segment
// whose mean is zero skips the last division.
// A zero-length segment skips the run.
// After reset the store is cleared one entry per cycle, and the input
// stalls until that is done.
// The result sits in an output register; while the receiver stalls it holds,
// and the block still takes samples of the next segment; the output stall
// holds up the block only when a second result is ready before the first
// is taken.
module segment_coverage_statistics #(
    parameter int MAX_LEN = scs_pkg::MAX_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [scs_pkg::POS_W-1:0] i_position,
    input  logic [scs_pkg::COV_W-1:0] i_coverage,
    input  logic                      i_last,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [scs_pkg::POS_W-1:0] o_segment_length,
    output logic [scs_pkg::SUM_W-1:0] o_mean_value,
    output logic [scs_pkg::VAR_W-1:0] o_pop_variance,
    output logic [scs_pkg::SD_W-1:0]  o_std_dev,
    output logic [scs_pkg::CV_W-1:0]  o_coef_var,
    output logic                      o_cv_undefined,
    output logic                      o_overflowed
);
    import scs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    scs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_last    (i_last),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    scs_dp #(
        .MAX_LEN(MAX_LEN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_position      (i_position),
        .i_coverage      (i_coverage),
        .i_last          (i_last),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_segment_length(o_segment_length),
        .o_mean_value    (o_mean_value),
        .o_pop_variance  (o_pop_variance),
        .o_std_dev       (o_std_dev),
        .o_coef_var      (o_coef_var),
        .o_cv_undefined  (o_cv_undefined),
        .o_overflowed    (o_overflowed)
    );

endmodule

// ===== src/scs_checker.sv =====
// Port-level checks for the segment coverage statistics block, bound to the top level.
module scs_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [scs_pkg::POS_W-1:0] o_segment_length,
    input logic [scs_pkg::SUM_W-1:0] o_mean_value,
    input logic [scs_pkg::VAR_W-1:0] o_pop_variance,
    input logic [scs_pkg::SD_W-1:0]  o_std_dev,
    input logic [scs_pkg::CV_W-1:0]  o_coef_var,
    input logic                      o_cv_undefined
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mean_value))
        else $error("stalled result dropped or changed");

    a_cv_zero_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cv_undefined == (o_mean_value == '0)) &&
                        (!o_cv_undefined || o_coef_var == '0))
        else $error("coefficient of variation flag mismatch");

    a_empty_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_segment_length == '0 |->
            o_mean_value == '0 && o_pop_variance == '0 && o_std_dev == '0)
        else $error("empty segment has nonzero statistics");

    // reset leaves the input stalled and no result valid
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("block not stalled after reset");

endmodule

bind segment_coverage_statistics scs_checker u_scs_checker (.*);
